FILE: src/pwct_pkg.sv
`timescale 1ns / 1ps

package pwct_pkg;

   // fixed field widths
   localparam int CODE_W     = 64;
   localparam int COUNT_W    = 7;
   localparam int REPEAT_W   = 8;
   localparam int TICK_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_TICKS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TICKS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICKS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS    = 3'd4;

   // register defaults
   localparam logic [REPEAT_W-1:0] RESET_REPEAT_COUNT = 8'd1;
   localparam logic [TICK_W-1:0]   RESET_HEADER_TICKS = 16'd6437;
   localparam logic [TICK_W-1:0]   RESET_SHORT_TICKS  = 16'd350;
   localparam logic [TICK_W-1:0]   RESET_LONG_TICKS   = 16'd700;
   localparam logic [TICK_W-1:0]   RESET_GAP_TICKS    = 16'd30000;

   // command codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // sequencer phases
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_BITS   = 2'd2;
   localparam logic [1:0] PH_GAP    = 2'd3;

   typedef struct packed {
      logic              cmd;
      logic [CODE_W-1:0] code_value;
      logic [COUNT_W-1:0] bit_count;
   } req_payload_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic rejected;
   } rsp_payload_type;

   typedef struct packed {
      logic [REPEAT_W-1:0] repeat_count;
      logic [TICK_W-1:0]   header_ticks;
      logic [TICK_W-1:0]   short_ticks;
      logic [TICK_W-1:0]   long_ticks;
      logic [TICK_W-1:0]   gap_ticks;
   } cfg_type;

endpackage

FILE: src/pwct_chan_if.sv
`timescale 1ns / 1ps

interface pwct_chan_if
   import pwct_pkg::*;
#(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/pwct_csr.sv
`timescale 1ns / 1ps

module pwct_csr
   import pwct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // write decode, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_REPEAT_COUNT: cfg_in.repeat_count = csr_wdata[REPEAT_W-1:0];
            CSR_HEADER_TICKS: cfg_in.header_ticks = csr_wdata[TICK_W-1:0];
            CSR_SHORT_TICKS:  cfg_in.short_ticks  = csr_wdata[TICK_W-1:0];
            CSR_LONG_TICKS:   cfg_in.long_ticks   = csr_wdata[TICK_W-1:0];
            CSR_GAP_TICKS:    cfg_in.gap_ticks    = csr_wdata[TICK_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_count <= RESET_REPEAT_COUNT;
         cfg_ff.header_ticks <= RESET_HEADER_TICKS;
         cfg_ff.short_ticks  <= RESET_SHORT_TICKS;
         cfg_ff.long_ticks   <= RESET_LONG_TICKS;
         cfg_ff.gap_ticks    <= RESET_GAP_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/pwct_seq.sv
`timescale 1ns / 1ps

module pwct_seq
   import pwct_pkg::*;
#(
   parameter int CODE_BITS  = 64,
   parameter int TIMER_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_payload_type item,
   input  cfg_type         cfg,
   output rsp_payload_type result
);

   localparam int CNT_W   = $clog2(CODE_BITS + 1);
   localparam int IDX_W   = $clog2(CODE_BITS);
   localparam int PAD_W   = 1 << IDX_W;
   localparam int LOAD_W  = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;
   localparam logic [LOAD_W-1:0] TIMER_MAX = LOAD_W'((64'd1 << TIMER_BITS) - 64'd1);

   logic [1:0]            phase_ff, phase_in;
   logic [TIMER_BITS-1:0] time_left_ff, time_left_in;
   logic [CNT_W-1:0]      bit_index_ff, bit_index_in;
   logic [REPEAT_W-1:0]   repeats_left_ff, repeats_left_in;
   logic [CODE_BITS-1:0]  code_store_ff, code_store_in;
   logic [CNT_W-1:0]      stored_count_ff, stored_count_in;
   logic                  level_ff, level_in;
   logic                  rej;

   logic [PAD_W-1:0]      code_pad;
   logic [CNT_W-1:0]      bits_left;
   logic [CNT_W-1:0]      sel_pos;
   logic                  sel_bit;
   logic [TICK_W-1:0]     seg_ticks;

   // segment length saturated to the timer
   function automatic logic [TIMER_BITS-1:0] sat_load(input logic [TICK_W-1:0] v);
      logic [LOAD_W-1:0] ext;
      ext = LOAD_W'(v);
      if (ext > TIMER_MAX) begin
         sat_load = TIMER_MAX[TIMER_BITS-1:0];
      end else begin
         sat_load = ext[TIMER_BITS-1:0];
      end
   endfunction

   // bit that the next bit segment sends
   assign code_pad  = PAD_W'(code_store_ff);
   assign bits_left = bit_index_ff - CNT_W'(1);
   assign sel_pos   = (phase_ff == PH_HEADER) ? stored_count_ff - CNT_W'(1)
                                              : bits_left - CNT_W'(1);
   assign sel_bit   = code_pad[sel_pos[IDX_W-1:0]];
   assign seg_ticks = sel_bit ? cfg.long_ticks : cfg.short_ticks;

   // next state for one request
   always_comb begin
      phase_in        = phase_ff;
      time_left_in    = time_left_ff;
      bit_index_in    = bit_index_ff;
      repeats_left_in = repeats_left_ff;
      code_store_in   = code_store_ff;
      stored_count_in = stored_count_ff;
      level_in        = level_ff;
      rej             = 1'b0;
      if (item.cmd == CMD_START) begin
         if (phase_ff != PH_IDLE) begin
            rej = 1'b1;
         end else if (cfg.repeat_count != '0) begin
            code_store_in   = item.code_value[CODE_BITS-1:0];
            stored_count_in = (item.bit_count > COUNT_W'(CODE_BITS)) ? CNT_W'(CODE_BITS)
                                                                     : CNT_W'(item.bit_count);
            repeats_left_in = cfg.repeat_count;
            bit_index_in    = '0;
            phase_in        = PH_HEADER;
            level_in        = 1'b1;
            time_left_in    = sat_load(cfg.header_ticks);
         end
      end else if (phase_ff != PH_IDLE) begin
         if (time_left_ff > TIMER_BITS'(1)) begin
            time_left_in = time_left_ff - TIMER_BITS'(1);
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  if (stored_count_ff == '0) begin
                     phase_in     = PH_GAP;
                     level_in     = 1'b0;
                     time_left_in = sat_load(cfg.gap_ticks);
                  end else begin
                     phase_in     = PH_BITS;
                     bit_index_in = stored_count_ff;
                     level_in     = 1'b0;
                     time_left_in = sat_load(seg_ticks);
                  end
               end
               PH_BITS: begin
                  bit_index_in = bits_left;
                  if (bits_left == '0) begin
                     phase_in     = PH_GAP;
                     level_in     = 1'b0;
                     time_left_in = sat_load(cfg.gap_ticks);
                  end else begin
                     level_in     = ~level_ff;
                     time_left_in = sat_load(seg_ticks);
                  end
               end
               PH_GAP: begin
                  repeats_left_in = repeats_left_ff - REPEAT_W'(1);
                  if (repeats_left_in == '0) begin
                     phase_in     = PH_IDLE;
                     level_in     = 1'b0;
                     time_left_in = '0;
                     bit_index_in = '0;
                  end else begin
                     phase_in     = PH_HEADER;
                     level_in     = 1'b1;
                     time_left_in = sat_load(cfg.header_ticks);
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         time_left_ff    <= '0;
         bit_index_ff    <= '0;
         repeats_left_ff <= '0;
         code_store_ff   <= '0;
         stored_count_ff <= '0;
         level_ff        <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         time_left_ff    <= time_left_in;
         bit_index_ff    <= bit_index_in;
         repeats_left_ff <= repeats_left_in;
         code_store_ff   <= code_store_in;
         stored_count_ff <= stored_count_in;
         level_ff        <= level_in;
      end
   end

   // answer for this request
   assign result.line_level = level_in;
   assign result.busy_res   = (phase_in != PH_IDLE);
   assign result.rejected   = rej;

   // line is low whenever nothing is being sent
   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !level_ff)
      else $error("line high while idle");

   // header always drives the line high
   a_header_high: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> level_ff)
      else $error("line low during header");

   // bit counter stays within the loaded code
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BITS |-> (bit_index_ff != '0) && (bit_index_ff <= stored_count_ff))
      else $error("bit index out of range");

   // a rejected start never disturbs a running frame
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      step && rej |=> (phase_ff == $past(phase_ff)) && (time_left_ff == $past(time_left_ff)))
      else $error("rejected start changed state");

endmodule

FILE: src/pulse_width_code_transmitter.sv
`timescale 1ns / 1ps
// path: an accepted request is held in the input register, its result in the
//   result register; a result that is not taken holds back the input register
// throughput: one request per cycle unless the output stalls; single-pass update
// reset: synchronous, active high; registers return to their defaults,
//   line low and idle, both pipeline stages empty

module pulse_width_code_transmitter
   import pwct_pkg::*;
#(
   parameter int CODE_BITS  = 64,
   parameter int TIMER_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   pwct_chan_if.sink             req_chan,
   pwct_chan_if.source           rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type         cfg;
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_item_ff;
   rsp_payload_type seq_result;
   logic            advance;
   logic            req_take;

   pwct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pwct_seq #(
      .CODE_BITS  (CODE_BITS),
      .TIMER_BITS (TIMER_BITS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (seq_result)
   );

   // pipeline flow control
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_item_ff <= seq_result;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

endmodule

FILE: tb/tb_pulse_width_code_transmitter.sv
`timescale 1ns / 1ps

module tb_pulse_width_code_transmitter;
   import pwct_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 500;
   localparam int DRAIN_CAP      = 300;
   localparam int PRINT_CAP      = 40;

   // indexes past the end of the register list
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_GAP_TICKS + 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = '1;

   localparam logic [TICK_W-1:0] LONG_SEG_TICKS = 16'd60;

   // expected line behavior and result checking
   class transmitter_scoreboard;
      cfg_type                regs;
      logic [1:0]             phase;
      logic [TICK_W-1:0]      remaining;
      logic [COUNT_W-1:0]     bits_left;
      logic [COUNT_W-1:0]     code_len;
      logic [REPEAT_W-1:0]    frames_left;
      logic [CODE_W-1:0]      code_bits;
      logic                   level;
      rsp_payload_type        expected_q[$];
      int                     mismatches;
      int                     checked;
      int                     starts;
      int                     rejects;
      int                     frames;

      function new();
         regs.repeat_count = RESET_REPEAT_COUNT;
         regs.header_ticks = RESET_HEADER_TICKS;
         regs.short_ticks  = RESET_SHORT_TICKS;
         regs.long_ticks   = RESET_LONG_TICKS;
         regs.gap_ticks    = RESET_GAP_TICKS;
         phase       = PH_IDLE;
         remaining   = '0;
         bits_left   = '0;
         code_len    = '0;
         frames_left = '0;
         code_bits   = '0;
         level       = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_REPEAT_COUNT: regs.repeat_count = data[REPEAT_W-1:0];
            CSR_HEADER_TICKS: regs.header_ticks = data;
            CSR_SHORT_TICKS:  regs.short_ticks  = data;
            CSR_LONG_TICKS:   regs.long_ticks   = data;
            CSR_GAP_TICKS:    regs.gap_ticks    = data;
            default: ;
         endcase
      endfunction

      function void begin_header();
         phase     = PH_HEADER;
         level     = 1'b1;
         remaining = regs.header_ticks;
         frames++;
      endfunction

      function void begin_gap();
         phase     = PH_GAP;
         level     = 1'b0;
         remaining = regs.gap_ticks;
      endfunction

      // segment length follows the current bit, msb first
      function void load_bit();
         remaining = code_bits[6'(bits_left - 7'd1)] ? regs.long_ticks : regs.short_ticks;
      endfunction

      function void note_request(req_payload_type r);
         rsp_payload_type want;
         logic            refused;
         refused = 1'b0;
         if (r.cmd == CMD_START) begin
            if (phase != PH_IDLE) begin
               refused = 1'b1;
               rejects++;
            end else if (regs.repeat_count != '0) begin
               code_bits   = r.code_value;
               code_len    = (r.bit_count > COUNT_W'(CODE_W)) ? COUNT_W'(CODE_W) : r.bit_count;
               frames_left = regs.repeat_count;
               bits_left   = '0;
               starts++;
               begin_header();
            end
         end else if (phase != PH_IDLE) begin
            if (remaining > 1) begin
               remaining--;
            end else begin
               // segment done, move on in the same tick
               case (phase)
                  PH_HEADER: begin
                     if (code_len == '0) begin
                        begin_gap();
                     end else begin
                        phase     = PH_BITS;
                        bits_left = code_len;
                        level     = 1'b0;
                        load_bit();
                     end
                  end
                  PH_BITS: begin
                     bits_left--;
                     if (bits_left == '0) begin
                        begin_gap();
                     end else begin
                        level = ~level;
                        load_bit();
                     end
                  end
                  PH_GAP: begin
                     frames_left--;
                     if (frames_left == '0) begin
                        phase     = PH_IDLE;
                        level     = 1'b0;
                        remaining = '0;
                        bits_left = '0;
                     end else begin
                        begin_header();
                     end
                  end
                  default: ;
               endcase
            end
         end
         want.line_level = level;
         want.busy_res   = (phase != PH_IDLE);
         want.rejected   = refused;
         expected_q.push_back(want);
      endfunction

      task report(string what, logic want, logic got);
         if (mismatches < PRINT_CAP)
            $display("ERROR %0t result %0d: %s expected %b got %b", $realtime, checked, what,
                     want, got);
         mismatches++;
      endtask

      task check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            report("result with no request waiting", 1'bx, got.line_level);
            return;
         end
         want = expected_q.pop_front();
         if (got.line_level !== want.line_level)
            report("line_level", want.line_level, got.line_level);
         if (got.busy_res !== want.busy_res)
            report("busy_res", want.busy_res, got.busy_res);
         if (got.rejected !== want.rejected)
            report("rejected", want.rejected, got.rejected);
         checked++;
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pwct_chan_if #(.payload_type(req_payload_type)) req_chan ();
   pwct_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   pulse_width_code_transmitter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   transmitter_scoreboard sb;
   bit src_idle_en;
   bit snk_stall_en;
   int stall_left;
   int quiet_cycles;
   int counted_items;

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // short gaps mostly, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [CODE_W-1:0] random_code();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         return '0;
      if (pick < 20)
         return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [COUNT_W-1:0] random_count();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return COUNT_W'($urandom_range(0, 16));
      if (pick < 80)
         return COUNT_W'($urandom_range(17, 63));
      if (pick < 90)
         return COUNT_W'(CODE_W);
      return COUNT_W'($urandom_range(CODE_W + 1, 127));
   endfunction

   function automatic logic [TICK_W-1:0] random_ticks();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         return '0;
      if (pick < 20)
         return TICK_W'(1);
      if (pick < 90)
         return TICK_W'($urandom_range(2, 6));
      return TICK_W'($urandom_range(7, 40));
   endfunction

   // response ready with random stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready = 1'b0;
      end else if (snk_stall_en && $urandom_range(0, 99) < 15) begin
         stall_left = pick_gap() - 1;
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = 1'b1;
      end
   end

   // monitor both channels and watch for a stuck run
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_request(req_chan.payload);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_response(rsp_chan.payload);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("pulse_width_code_transmitter: mismatch");
            $finish;
         end
      end
   end

   // one request, with an optional idle gap in front
   task automatic send_request(input req_payload_type r);
      int gap;
      gap = (src_idle_en && $urandom_range(0, 99) < 20) ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.payload = r;
      req_chan.valid   = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic cmd, input logic [CODE_W-1:0] code,
                              input logic [COUNT_W-1:0] count);
      req_payload_type r;
      r.cmd        = cmd;
      r.code_value = code;
      r.bit_count  = count;
      send_request(r);
   endtask

   // tick until the line goes idle, bounded
   task automatic drain_line(input int cap);
      int n;
      n = 0;
      while (sb.phase != PH_IDLE && n < cap) begin
         send_fields(CMD_TICK, random_code(), COUNT_W'($urandom));
         n++;
      end
   endtask

   // empty the pipeline before touching registers
   task automatic settle();
      req_chan.valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_reg(idx, data);
   endtask

   task automatic write_timing(input logic [TICK_W-1:0] hdr, input logic [TICK_W-1:0] shrt,
                               input logic [TICK_W-1:0] lng, input logic [TICK_W-1:0] gap);
      write_reg(CSR_HEADER_TICKS, hdr);
      write_reg(CSR_SHORT_TICKS, shrt);
      write_reg(CSR_LONG_TICKS, lng);
      write_reg(CSR_GAP_TICKS, gap);
   endtask

   // new settings for a random phase, some registers left as they were
   task automatic randomize_config();
      int                  pick;
      logic [REPEAT_W-1:0] reps;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         reps = '0;
      else if (pick < 10)
         reps = '1;
      else
         reps = REPEAT_W'($urandom_range(1, 3));
      if ($urandom_range(0, 99) < 60)
         write_reg(CSR_REPEAT_COUNT, {8'($urandom), reps});
      if ($urandom_range(0, 99) < 60)
         write_reg(CSR_HEADER_TICKS, random_ticks());
      if ($urandom_range(0, 99) < 60)
         write_reg(CSR_SHORT_TICKS, random_ticks());
      if ($urandom_range(0, 99) < 60)
         write_reg(CSR_LONG_TICKS, random_ticks());
      if ($urandom_range(0, 99) < 60)
         write_reg(CSR_GAP_TICKS, random_ticks());
      if ($urandom_range(0, 99) < 10)
         write_reg(CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), CSR_DATA_W'($urandom));
   endtask

   // mostly well-formed: start when idle, tick while busy
   task automatic random_item(output bit counted);
      req_payload_type r;
      bit              busy;
      busy = (sb.phase != PH_IDLE);
      if (busy)
         r.cmd = ($urandom_range(0, 99) < 5) ? CMD_START : CMD_TICK;
      else
         r.cmd = ($urandom_range(0, 99) < 60) ? CMD_START : CMD_TICK;
      r.code_value = random_code();
      r.bit_count  = random_count();
      counted = ((r.cmd == CMD_START) != busy);
      send_request(r);
   endtask

   initial begin
      bit c;
      int n;
      sb              = new();
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      src_idle_en     = 1'b1;
      snk_stall_en    = 1'b1;
      stall_left      = 0;
      quiet_cycles    = 0;
      counted_items   = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // tick while idle keeps the line low
      send_fields(CMD_TICK, '1, '1);
      settle();
      write_reg(CSR_REPEAT_COUNT, 16'd1);
      write_timing(16'd2, 16'd1, 16'd2, 16'd1);

      // oversize count clamps to the code width, a second start is refused
      send_fields(CMD_START, '1, '1);
      send_fields(CMD_START, '0, 7'd5);
      drain_line(1000);
      send_fields(CMD_START, '0, COUNT_W'(CODE_W));
      drain_line(1000);

      // no bits: header then gap
      send_fields(CMD_START, 64'hA5, '0);
      drain_line(1000);

      // zero repeat count: start does nothing
      settle();
      write_reg(CSR_REPEAT_COUNT, 16'hFF00);
      send_fields(CMD_START, 64'h3C, 7'd4);
      send_fields(CMD_TICK, '0, '0);

      // zero-length segments last one tick
      settle();
      write_reg(CSR_REPEAT_COUNT, 16'd2);
      write_timing('0, '0, '0, '0);
      send_fields(CMD_START, 64'h5, 7'd3);
      drain_line(1000);

      // lengths read per segment, repeat count only at start
      settle();
      write_reg(CSR_REPEAT_COUNT, 16'd2);
      write_timing(16'd4, 16'd3, 16'd5, 16'd2);
      send_fields(CMD_START, 64'h6, 7'd3);
      send_fields(CMD_TICK, '0, '0);
      send_fields(CMD_TICK, '1, '1);
      settle();
      write_reg(CSR_REPEAT_COUNT, 16'd9);
      write_timing(16'd1, 16'd1, 16'd7, 16'd4);
      drain_line(1000);

      // writes past the register list are ignored
      settle();
      write_reg(CSR_SPARE_LO, '1);
      write_reg(CSR_SPARE_HI, '0);

      // largest repeat count
      write_reg(CSR_REPEAT_COUNT, 16'd255);
      write_timing('0, 16'd1, 16'd1, '0);
      send_fields(CMD_START, '0, '0);
      drain_line(2000);

      // long segments with no idling on either side
      settle();
      src_idle_en  = 1'b0;
      snk_stall_en = 1'b0;
      write_reg(CSR_REPEAT_COUNT, 16'd1);
      write_timing(LONG_SEG_TICKS, LONG_SEG_TICKS, LONG_SEG_TICKS, LONG_SEG_TICKS);
      send_fields(CMD_START, '1, 7'd1);
      drain_line(DRAIN_CAP);

      // random phases, settings change between them
      while (counted_items < RANDOM_ITEMS) begin
         settle();
         randomize_config();
         src_idle_en  = ($urandom_range(0, 99) < 75);
         snk_stall_en = ($urandom_range(0, 99) < 75);
         n = $urandom_range(20, 80);
         repeat (n) begin
            random_item(c);
            if (c)
               counted_items++;
         end
         if ($urandom_range(0, 3) == 0)
            drain_line(DRAIN_CAP);
      end

      // wait out the remaining results
      settle();
      repeat (10) @(negedge clock);

      $display("covered %0d results over %0d frames: %0d code starts, %0d refused while busy",
               sb.checked, sb.frames, sb.starts, sb.rejects);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("pulse_width_code_transmitter: match");
      else
         $display("pulse_width_code_transmitter: mismatch");
      $finish;
   end

endmodule
